// ----- design/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// hse_pkg
// shared types and constants of the heap sort engine: payload widths of the
// request and response channels
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

   // width of a key on the channels
   localparam int unsigned KEY_W = 32;

   typedef logic signed [KEY_W-1:0] key_type;

endpackage

`default_nettype wire

// ----- design/hse_req_if.sv -----
// ----------------------------------------------------------------------------
// hse_req_if
// request channel of the heap sort engine: one key per transaction and a
// marker that closes the set
// ----------------------------------------------------------------------------
`default_nettype none

interface hse_req_if;

   logic             valid;
   logic             ready;
   hse_pkg::key_type key;
   logic             last_in;

   modport source (output valid, output key, output last_in, input ready);
   modport sink   (input valid, input key, input last_in, output ready);

endinterface

`default_nettype wire

// ----- design/hse_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hse_rsp_if
// response channel of the heap sort engine: one sorted key per transaction
// with end-of-set and overflow markers
// ----------------------------------------------------------------------------
`default_nettype none

interface hse_rsp_if;

   logic             valid;
   logic             ready;
   hse_pkg::key_type sorted_key;
   logic             last_out;
   logic             dropped;

   modport source (output valid, output sorted_key, output last_out, output dropped,
                   input ready);
   modport sink   (input valid, input sorted_key, input last_out, input dropped,
                   output ready);

endinterface

`default_nettype wire

// ----- design/heap_sort_engine.sv -----
// ----------------------------------------------------------------------------
// heap_sort_engine
// collects a set of signed keys and returns them in ascending order, sorted
// in place by heapsort in one two-read, one-write synchronous memory
// ----------------------------------------------------------------------------
// usage
//   req_chan  one key per transaction; last_in closes the set and starts the
//             sort. req_chan.ready is high only while keys are being loaded.
//   rsp_chan  one transaction per stored key, ascending; last_out marks the
//             final key, dropped is set in every transaction of a set in
//             which keys arrived with the store already full (DEPTH keys)
// timing
//   loading accepts one key per cycle. sorting n keys runs a sift-down walk on
//   the key memory: each tree level reads both children, then compares and
//   writes one entry; each build node first reads and loads its key, and each
//   extraction checks the heap size, reads root and last leaf, then swaps.
//   output then steps through read, register and handshake for each key, and
//   waits while the receiver holds ready low.
//   while a set is being sorted or emitted no new key is accepted.
// reset
//   synchronous, active high: empties the set and clears the overflow mark;
//   the key memory itself is not cleared, only written entries are read
// stalls
//   a response waits in the output register until taken; nothing is lost
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine #(
   parameter int unsigned DEPTH     = 64,
   parameter int unsigned KEY_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hse_req_if.sink    req_chan,
   hse_rsp_if.source  rsp_chan
);

   localparam int unsigned AW    = $clog2(DEPTH);       // memory address bits
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);   // counts 0..DEPTH
   localparam int unsigned CW    = AW + 2;              // child index bits

   // sequencer states
   localparam logic [3:0] ST_LOAD     = 4'd0;
   localparam logic [3:0] ST_BLD_RD   = 4'd1;
   localparam logic [3:0] ST_BLD_LD   = 4'd2;
   localparam logic [3:0] ST_SIFT_RD  = 4'd3;
   localparam logic [3:0] ST_SIFT_CMP = 4'd4;
   localparam logic [3:0] ST_EXT_CHK  = 4'd5;
   localparam logic [3:0] ST_EXT_RD   = 4'd6;
   localparam logic [3:0] ST_EXT_SWAP = 4'd7;
   localparam logic [3:0] ST_OUT_RD   = 4'd8;
   localparam logic [3:0] ST_OUT_LD   = 4'd9;
   localparam logic [3:0] ST_OUT_WAIT = 4'd10;

   // key memory, read data registered
   logic signed [KEY_WIDTH-1:0] heap_mem_ff [DEPTH];
   logic signed [KEY_WIDTH-1:0] rd_a_ff;
   logic signed [KEY_WIDTH-1:0] rd_b_ff;
   logic [AW-1:0]               rd_addr_a;
   logic [AW-1:0]               rd_addr_b;
   logic                        mem_we;
   logic [AW-1:0]               mem_wa;
   logic signed [KEY_WIDTH-1:0] mem_wd;

   // control state
   logic [3:0]       state_ff,   state_in;
   logic [CNT_W-1:0] count_ff,   count_in;    // keys stored in this set
   logic             ovf_ff,     ovf_in;      // a key of this set was dropped
   logic [CNT_W-1:0] n_ff,       n_in;        // keys to sort
   logic [AW-1:0]    bld_ff,     bld_in;      // build-phase node
   logic             extract_ff, extract_in;  // sift belongs to extraction
   logic [CNT_W-1:0] i_ff,       i_in;        // live heap size in extraction
   logic [AW-1:0]    node_ff,    node_in;     // hole of the sift-down walk
   logic [CNT_W-1:0] size_ff,    size_in;     // heap size of the walk
   logic [AW-1:0]    out_idx_ff, out_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [KEY_WIDTH-1:0] v_ff, v_in;   // key carried down the walk
   hse_pkg::key_type            key_out_ff, key_out_in;
   logic                        last_out_ff, last_out_in;
   logic                        dropped_ff, dropped_in;

   logic                        req_accept;
   logic                        room;
   logic [CNT_W-1:0]            n_next;
   logic signed [KEY_WIDTH-1:0] key_ext;
   hse_pkg::key_type            key_conv;
   logic [CW-1:0]               l_idx;
   logic [CW-1:0]               r_idx;
   logic                        l_gt;
   logic                        r_gt;
   logic signed [KEY_WIDTH-1:0] big_val;

   // key format between channel width and storage width
   if (KEY_WIDTH > hse_pkg::KEY_W) begin : g_in_wide
      assign key_ext = {{(KEY_WIDTH - hse_pkg::KEY_W){req_chan.key[hse_pkg::KEY_W-1]}},
                        req_chan.key};
   end else begin : g_in_narrow
      assign key_ext = req_chan.key[KEY_WIDTH-1:0];
   end

   if (KEY_WIDTH < hse_pkg::KEY_W) begin : g_out_narrow
      assign key_conv = {{(hse_pkg::KEY_W - KEY_WIDTH){rd_a_ff[KEY_WIDTH-1]}}, rd_a_ff};
   end else begin : g_out_wide
      assign key_conv = rd_a_ff[hse_pkg::KEY_W-1:0];
   end

   assign req_chan.ready      = (state_ff == ST_LOAD);
   assign req_accept          = req_chan.valid & req_chan.ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sorted_key = key_out_ff;
   assign rsp_chan.last_out   = last_out_ff;
   assign rsp_chan.dropped    = dropped_ff;

   assign room   = (count_ff < CNT_W'(DEPTH));
   assign n_next = room ? count_ff + CNT_W'(1) : count_ff;

   // children of the hole and the strict-greater child choice
   assign l_idx   = {1'b0, node_ff, 1'b1};
   assign r_idx   = l_idx + CW'(1);
   assign l_gt    = (l_idx < CW'(size_ff)) && (rd_a_ff > v_ff);
   assign big_val = l_gt ? rd_a_ff : v_ff;
   assign r_gt    = (r_idx < CW'(size_ff)) && (rd_b_ff > big_val);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      bld_in       = bld_ff;
      extract_in   = extract_ff;
      i_in         = i_ff;
      node_in      = node_ff;
      size_in      = size_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      v_in         = v_ff;
      key_out_in   = key_out_ff;
      last_out_in  = last_out_ff;
      dropped_in   = dropped_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = v_ff;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (room) begin
                  mem_we   = 1'b1;
                  mem_wa   = count_ff[AW-1:0];
                  mem_wd   = key_ext;
                  count_in = n_next;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last_in) begin
                  n_in       = n_next;
                  extract_in = 1'b0;
                  if ((n_next >> 1) == '0) begin
                     i_in     = n_next;
                     state_in = ST_EXT_CHK;
                  end else begin
                     bld_in   = AW'((n_next >> 1) - CNT_W'(1));
                     state_in = ST_BLD_RD;
                  end
               end
            end
         end
         ST_BLD_RD: begin
            rd_addr_a = bld_ff;
            state_in  = ST_BLD_LD;
         end
         ST_BLD_LD: begin
            v_in     = rd_a_ff;
            node_in  = bld_ff;
            size_in  = n_ff;
            state_in = ST_SIFT_RD;
         end
         ST_SIFT_RD: begin
            rd_addr_a = l_idx[AW-1:0];
            rd_addr_b = r_idx[AW-1:0];
            state_in  = ST_SIFT_CMP;
         end
         ST_SIFT_CMP: begin
            mem_we = 1'b1;
            mem_wa = node_ff;
            if (r_gt) begin
               mem_wd   = rd_b_ff;
               node_in  = r_idx[AW-1:0];
               state_in = ST_SIFT_RD;
            end else if (l_gt) begin
               mem_wd   = rd_a_ff;
               node_in  = l_idx[AW-1:0];
               state_in = ST_SIFT_RD;
            end else begin
               // hole found its place: drop the carried key there
               mem_wd = v_ff;
               if (extract_ff) begin
                  state_in = ST_EXT_CHK;
               end else if (bld_ff == '0) begin
                  i_in     = n_ff;
                  state_in = ST_EXT_CHK;
               end else begin
                  bld_in   = bld_ff - AW'(1);
                  state_in = ST_BLD_RD;
               end
            end
         end
         ST_EXT_CHK: begin
            extract_in = 1'b1;
            if (i_ff > CNT_W'(1)) begin
               state_in = ST_EXT_RD;
            end else begin
               out_idx_in = '0;
               state_in   = ST_OUT_RD;
            end
         end
         ST_EXT_RD: begin
            rd_addr_a = '0;
            rd_addr_b = AW'(i_ff - CNT_W'(1));
            state_in  = ST_EXT_SWAP;
         end
         ST_EXT_SWAP: begin
            // root goes to the end, last leaf is carried down from the root
            mem_we   = 1'b1;
            mem_wa   = AW'(i_ff - CNT_W'(1));
            mem_wd   = rd_a_ff;
            v_in     = rd_b_ff;
            node_in  = '0;
            size_in  = i_ff - CNT_W'(1);
            i_in     = i_ff - CNT_W'(1);
            state_in = ST_SIFT_RD;
         end
         ST_OUT_RD: begin
            rd_addr_a = out_idx_ff;
            state_in  = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            key_out_in   = key_conv;
            last_out_in  = ((CNT_W'(out_idx_ff) + CNT_W'(1)) == n_ff);
            dropped_in   = ovf_ff;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (last_out_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  out_idx_in = out_idx_ff + AW'(1);
                  state_in   = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // key memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem_ff[mem_wa] <= mem_wd;
      end
      rd_a_ff <= heap_mem_ff[rd_addr_a];
      rd_b_ff <= heap_mem_ff[rd_addr_b];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         n_ff         <= '0;
         bld_ff       <= '0;
         extract_ff   <= 1'b0;
         i_ff         <= '0;
         node_ff      <= '0;
         size_ff      <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         n_ff         <= n_in;
         bld_ff       <= bld_in;
         extract_ff   <= extract_in;
         i_ff         <= i_in;
         node_ff      <= node_in;
         size_ff      <= size_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      key_out_ff  <= key_out_in;
      last_out_ff <= last_out_in;
      dropped_ff  <= dropped_in;
   end

`ifndef ASSERT_OFF
   // store never counts past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("key count beyond capacity");

   // the sift hole always lies inside the live heap
   a_node_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIFT_CMP) |-> (CNT_W'(node_ff) < size_ff))
      else $error("sift node outside heap");

   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_valid_ff))
      else $error("request ready while a response is pending");

   // the final response of a set empties the store
   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_chan.ready && last_out_ff)
         |=> (count_ff == '0) && !ovf_ff && (state_ff == ST_LOAD))
      else $error("store not emptied after final response");
`endif

endmodule

`default_nettype wire
